// ===== src/id3p_pkg.sv =====
// Shared types, result codes and header constants for the ID3v2 frame stream parser.
// Depends on nothing; every other file of the block imports it.
package id3p_pkg;

  localparam int unsigned POS_W = 29;

  localparam logic [1:0] KIND_FRAME_HDR = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
  localparam logic [1:0] KIND_TAG_DONE  = 2'd2;
  localparam logic [1:0] KIND_NOT_ID3   = 2'd3;

  localparam logic [POS_W-1:0] TAG_HDR_LEN = 29'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] frame_id;
    logic [31:0] frame_length;
    logic [15:0] frame_flags;
    logic [7:0]  tag_version;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic        tag_end;
  } out_beat_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'h49;
      2'd1:    val = 8'h44;
      default: val = 8'h33;
    endcase
    return val;
  endfunction

endpackage

// ===== src/id3p_parse.sv =====
// Input register and parser state for the ID3v2 frame stream parser.
// One registered byte is consumed per step; the step logic builds at most one result.
// Depends on id3p_pkg.
module id3p_parse
  import id3p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  input  logic      out_free,
  output logic      res_valid,
  output out_beat_t res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_TAGHDR  = 3'd1;
  localparam logic [2:0] PH_FRMHDR  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_DONE    = 3'd4;

  logic             q_valid;
  in_beat_t         q;
  logic             advance;

  logic [2:0]       phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [POS_W-1:0] tag_end_position, tag_end_position_next;
  logic [7:0]       major_version, major_version_next;
  logic [3:0]       field_counter, field_counter_next;
  logic [31:0]      id_accumulator, id_accumulator_next;
  logic [31:0]      size_accumulator, size_accumulator_next;
  logic [15:0]      flags_accumulator, flags_accumulator_next;
  logic [31:0]      payload_remaining, payload_remaining_next;

  logic [2:0]       cur_phase;
  logic [POS_W-1:0] cur_pos, cur_tag_end;
  logic [7:0]       cur_major;
  logic [3:0]       cur_fc, fc_inc, id_len, hdr_len;
  logic [31:0]      cur_id, cur_size, cur_rem, id_base, size_base;
  logic [15:0]      cur_flags, flags_base;
  logic             hit;
  out_beat_t        res_c;

  assign advance  = q_valid && out_free;
  assign in_stall = q_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (!in_stall) begin
      q_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      q <= in_beat;
    end
  end

  always_comb begin
    cur_phase   = phase;
    cur_pos     = byte_position;
    cur_tag_end = tag_end_position;
    cur_major   = major_version;
    cur_fc      = field_counter;
    cur_id      = id_accumulator;
    cur_size    = size_accumulator;
    cur_flags   = flags_accumulator;
    cur_rem     = payload_remaining;
    if (q.file_start) begin
      cur_phase   = PH_TAGHDR;
      cur_pos     = '0;
      cur_tag_end = '0;
      cur_major   = '0;
      cur_fc      = '0;
      cur_id      = '0;
      cur_size    = '0;
      cur_flags   = '0;
      cur_rem     = '0;
    end

    phase_next             = cur_phase;
    byte_position_next     = cur_pos;
    tag_end_position_next  = cur_tag_end;
    major_version_next     = cur_major;
    field_counter_next     = cur_fc;
    id_accumulator_next    = cur_id;
    size_accumulator_next  = cur_size;
    flags_accumulator_next = cur_flags;
    payload_remaining_next = cur_rem;

    id_len     = (cur_major > 8'd2) ? 4'd4 : 4'd3;
    hdr_len    = (cur_major > 8'd2) ? 4'd10 : 4'd6;
    fc_inc     = cur_fc + 4'd1;
    id_base    = (cur_fc == 4'd0) ? 32'd0 : cur_id;
    size_base  = (cur_fc == 4'd0) ? 32'd0 : cur_size;
    flags_base = (cur_fc == 4'd0) ? 16'd0 : cur_flags;

    hit   = 1'b0;
    res_c = '0;

    unique case (cur_phase)
      PH_TAGHDR: begin
        if (cur_pos < 29'd3 && q.data_byte != magic_byte(cur_pos[1:0])) begin
          hit        = 1'b1;
          res_c.kind = KIND_NOT_ID3;
          phase_next = PH_DONE;
        end else begin
          if (cur_pos == 29'd3) begin
            major_version_next = q.data_byte;
          end
          if (cur_pos >= 29'd6) begin
            size_accumulator_next = {cur_size[24:0], q.data_byte[6:0]};
          end
          byte_position_next = cur_pos + 29'd1;
          if (cur_pos >= 29'd9) begin
            tag_end_position_next = {1'b0, size_accumulator_next[27:0]} + TAG_HDR_LEN;
            size_accumulator_next = '0;
            field_counter_next    = '0;
            phase_next            = PH_FRMHDR;
            if (byte_position_next >= tag_end_position_next) begin
              hit               = 1'b1;
              res_c.kind        = KIND_TAG_DONE;
              res_c.tag_version = major_version_next;
              phase_next        = PH_DONE;
            end
          end
        end
      end
      PH_FRMHDR: begin
        id_accumulator_next    = id_base;
        size_accumulator_next  = size_base;
        flags_accumulator_next = flags_base;
        if (cur_fc < id_len) begin
          id_accumulator_next = {id_base[23:0], q.data_byte};
        end else if (cur_fc < {id_len[2:0], 1'b0}) begin
          size_accumulator_next = {size_base[23:0], q.data_byte};
        end else begin
          flags_accumulator_next = {flags_base[7:0], q.data_byte};
        end
        field_counter_next = fc_inc;
        byte_position_next = cur_pos + 29'd1;
        if (fc_inc >= hdr_len) begin
          field_counter_next = '0;
          hit                = 1'b1;
          res_c.tag_version  = cur_major;
          if (size_accumulator_next == 32'd0 ||
              ({4'd0, byte_position_next} + {1'b0, size_accumulator_next}) >
              {4'd0, cur_tag_end}) begin
            res_c.kind = KIND_TAG_DONE;
            phase_next = PH_DONE;
          end else begin
            payload_remaining_next = size_accumulator_next;
            phase_next             = PH_PAYLOAD;
            res_c.kind             = KIND_FRAME_HDR;
            res_c.frame_id         = id_accumulator_next;
            res_c.frame_length     = size_accumulator_next;
            res_c.frame_flags      = flags_accumulator_next;
          end
        end
      end
      PH_PAYLOAD: begin
        payload_remaining_next = cur_rem - 32'd1;
        byte_position_next     = cur_pos + 29'd1;
        hit                    = 1'b1;
        res_c.kind             = KIND_PAYLOAD;
        res_c.frame_id         = cur_id;
        res_c.frame_length     = cur_size;
        res_c.frame_flags      = cur_flags;
        res_c.tag_version      = cur_major;
        res_c.payload_byte     = q.data_byte;
        if (payload_remaining_next == 32'd0) begin
          res_c.last_of_frame = 1'b1;
          if (byte_position_next >= cur_tag_end) begin
            res_c.tag_end = 1'b1;
            phase_next    = PH_DONE;
          end else begin
            field_counter_next = '0;
            phase_next         = PH_FRMHDR;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      byte_position     <= '0;
      tag_end_position  <= '0;
      major_version     <= '0;
      field_counter     <= '0;
      id_accumulator    <= '0;
      size_accumulator  <= '0;
      flags_accumulator <= '0;
      payload_remaining <= '0;
    end else if (advance) begin
      phase             <= phase_next;
      byte_position     <= byte_position_next;
      tag_end_position  <= tag_end_position_next;
      major_version     <= major_version_next;
      field_counter     <= field_counter_next;
      id_accumulator    <= id_accumulator_next;
      size_accumulator  <= size_accumulator_next;
      flags_accumulator <= flags_accumulator_next;
      payload_remaining <= payload_remaining_next;
    end
  end

  assign res_valid = advance && hit;
  assign res       = res_c;

  // A frame in progress never reaches past the end of the tag.
  a_payload_in_tag: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |->
      payload_remaining != 32'd0 &&
      ({4'd0, byte_position} + {1'b0, payload_remaining}) <= {4'd0, tag_end_position})
    else $error("payload walk overruns the tag end");

  // A rejected magic leaves the parser stopped inside the first three bytes.
  a_bad_magic_stops: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_NOT_ID3 |=>
      phase == PH_DONE && byte_position < 29'd3)
    else $error("bad magic did not stop the parser");

  // The end of the tag is only flagged on the last byte of a frame.
  a_tag_end_is_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.tag_end |-> res.kind == KIND_PAYLOAD && res.last_of_frame)
    else $error("tag end flagged off a frame boundary");

  // A consumed start byte always leaves the parser out of idle.
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    advance && q.file_start |=> phase != PH_IDLE)
    else $error("file start left the parser idle");

endmodule

// ===== src/id3p_out_reg.sv =====
// Result register for the ID3v2 frame stream parser.
// Holds one result beat until the downstream side takes it; depends on id3p_pkg.
module id3p_out_reg
  import id3p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      res_valid,
  input  out_beat_t res,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
    if (out_free && res_valid) begin
      out_beat <= res;
    end
  end

endmodule

// ===== src/id3v2_frame_stream_parser_core.sv =====
// Stream parser for ID3v2 tags and their frame headers, one file byte per beat.
// A byte with file_start set restarts the parser and counts as byte zero of the file.
// The block takes one byte every cycle while the result side keeps up; a byte's result,
// if it has one, passes from the input register through the single step of parser logic
// into the result register. When the result register is held by out_stall, the byte
// already in the input register waits and in_stall rises.
// Results: a header record per accepted frame, then one beat per payload byte with the
// last one marked, a tag-done beat when parsing stops on a header, or a not-ID3 beat.
module id3v2_frame_stream_parser_core
  import id3p_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  logic      out_free;
  logic      res_valid;
  out_beat_t res;

  id3p_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_free (out_free),
    .res_valid(res_valid),
    .res      (res)
  );

  id3p_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid),
    .res      (res),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

endmodule

// ===== verif/tb_id3v2_frame_stream_parser_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for id3v2_frame_stream_parser_core: a directed table, then random files.
// Each accepted byte runs through a local copy of the parser that predicts the result beats.
// Depends on id3p_pkg and the RTL of the block only.
module tb_id3v2_frame_stream_parser_core;
  import id3p_pkg::*;

  localparam int unsigned BYTE_TARGET = 1650;
  localparam int unsigned PHASE_LEN = 200;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam logic [23:0] ID3_MAGIC = 24'h494433;

  typedef enum logic [2:0] {
    ST_WAIT_START,
    ST_TAG_HEADER,
    ST_FRAME_HEADER,
    ST_PAYLOAD,
    ST_STOPPED
  } parse_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
    out_beat_t  record;
  } table_row_t;

  localparam out_beat_t NO_RECORD = '0;
  localparam out_beat_t NOT_ID3_RECORD =
    '{KIND_NOT_ID3, 32'h0, 32'h0, 16'h0, 8'h00, 8'h00, 1'b0, 1'b0};
  localparam out_beat_t TT2_HEADER_RECORD =
    '{KIND_FRAME_HDR, 32'h0054_5432, 32'd1, 16'h0, 8'h02, 8'h00, 1'b0, 1'b0};
  localparam out_beat_t TT2_LAST_RECORD =
    '{KIND_PAYLOAD, 32'h0054_5432, 32'd1, 16'h0, 8'h02, 8'hFF, 1'b1, 1'b1};

  localparam table_row_t DIRECTED_ROWS [22] = '{
    '{8'h00, 1'b1, 1'b1, NOT_ID3_RECORD},
    '{8'hAA, 1'b0, 1'b0, NO_RECORD},
    '{8'h49, 1'b1, 1'b0, NO_RECORD},
    '{8'h44, 1'b0, 1'b0, NO_RECORD},
    '{8'h49, 1'b1, 1'b0, NO_RECORD},
    '{8'h44, 1'b0, 1'b0, NO_RECORD},
    '{8'h33, 1'b0, 1'b0, NO_RECORD},
    '{8'h02, 1'b0, 1'b0, NO_RECORD},
    '{8'hFF, 1'b0, 1'b0, NO_RECORD},
    '{8'h00, 1'b0, 1'b0, NO_RECORD},
    '{8'h80, 1'b0, 1'b0, NO_RECORD},
    '{8'h80, 1'b0, 1'b0, NO_RECORD},
    '{8'h80, 1'b0, 1'b0, NO_RECORD},
    '{8'h87, 1'b0, 1'b0, NO_RECORD},
    '{8'h54, 1'b0, 1'b0, NO_RECORD},
    '{8'h54, 1'b0, 1'b0, NO_RECORD},
    '{8'h32, 1'b0, 1'b0, NO_RECORD},
    '{8'h00, 1'b0, 1'b0, NO_RECORD},
    '{8'h00, 1'b0, 1'b0, NO_RECORD},
    '{8'h01, 1'b0, 1'b1, TT2_HEADER_RECORD},
    '{8'hFF, 1'b0, 1'b1, TT2_LAST_RECORD},
    '{8'h00, 1'b0, 1'b0, NO_RECORD}
  };

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  logic      typed_now = 1'b0;
  out_beat_t typed_record = '0;

  out_beat_t   pending_records [$];
  int unsigned mismatches = 0;
  int unsigned bytes_sent = 0;
  int unsigned idle_mode = 0;
  int unsigned quiet_cycles = 0;

  parse_state_t     pstate;
  logic [POS_W-1:0] file_pos;
  logic [POS_W-1:0] tag_end_pos;
  logic [7:0]       major_ver;
  logic [3:0]       hdr_count;
  logic [31:0]      id_acc;
  logic [31:0]      size_acc;
  logic [15:0]      flags_acc;
  logic [31:0]      bytes_left;

  id3v2_frame_stream_parser_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void clear_parser();
    pstate = ST_WAIT_START;
    file_pos = '0;
    tag_end_pos = '0;
    major_ver = '0;
    hdr_count = '0;
    id_acc = '0;
    size_acc = '0;
    flags_acc = '0;
    bytes_left = '0;
  endfunction

  function automatic bit parse_file_byte(input logic [7:0] b, input logic start,
                                         output out_beat_t rec);
    logic [POS_W-1:0] p;
    logic [3:0]       k;
    logic [3:0]       id_len;
    logic [3:0]       hdr_len;
    bit               wide;
    rec = '0;
    if (start) begin
      clear_parser();
      pstate = ST_TAG_HEADER;
    end
    case (pstate)
      ST_TAG_HEADER: begin
        p = file_pos;
        if (p < 3) begin
          if (b != ID3_MAGIC[8*(2 - int'(p[1:0])) +: 8]) begin
            rec.kind = KIND_NOT_ID3;
            pstate = ST_STOPPED;
            return 1'b1;
          end
        end else if (p == 3) begin
          major_ver = b;
        end else if (p >= 6) begin
          size_acc = {size_acc[24:0], b[6:0]};
        end
        file_pos = file_pos + 1'b1;
        if (p >= 9) begin
          tag_end_pos = {1'b0, size_acc[27:0]} + TAG_HDR_LEN;
          size_acc = '0;
          hdr_count = '0;
          pstate = ST_FRAME_HEADER;
          if (file_pos >= tag_end_pos) begin
            rec.kind = KIND_TAG_DONE;
            rec.tag_version = major_ver;
            pstate = ST_STOPPED;
            return 1'b1;
          end
        end
        return 1'b0;
      end
      ST_FRAME_HEADER: begin
        wide = major_ver > 8'd2;
        id_len = wide ? 4'd4 : 4'd3;
        hdr_len = wide ? 4'd10 : 4'd6;
        k = hdr_count;
        if (k == 0) begin
          id_acc = '0;
          size_acc = '0;
          flags_acc = '0;
        end
        if (k < id_len) id_acc = {id_acc[23:0], b};
        else if (k < 2 * id_len) size_acc = {size_acc[23:0], b};
        else flags_acc = {flags_acc[7:0], b};
        hdr_count = k + 1'b1;
        file_pos = file_pos + 1'b1;
        if (hdr_count >= hdr_len) begin
          hdr_count = '0;
          if (size_acc == 0 || 34'(file_pos) + 34'(size_acc) > 34'(tag_end_pos)) begin
            rec.kind = KIND_TAG_DONE;
            rec.tag_version = major_ver;
            pstate = ST_STOPPED;
            return 1'b1;
          end
          bytes_left = size_acc;
          pstate = ST_PAYLOAD;
          rec = '{KIND_FRAME_HDR, id_acc, size_acc, flags_acc, major_ver, 8'h00, 1'b0, 1'b0};
          return 1'b1;
        end
        return 1'b0;
      end
      ST_PAYLOAD: begin
        bytes_left = bytes_left - 1'b1;
        file_pos = file_pos + 1'b1;
        rec = '{KIND_PAYLOAD, id_acc, size_acc, flags_acc, major_ver, b, 1'b0, 1'b0};
        if (bytes_left == 0) begin
          rec.last_of_frame = 1'b1;
          if (file_pos >= tag_end_pos) begin
            rec.tag_end = 1'b1;
            pstate = ST_STOPPED;
          end else begin
            hdr_count = '0;
            pstate = ST_FRAME_HEADER;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic check_result_beat(input out_beat_t want, input out_beat_t got);
    if (want.kind !== got.kind) begin
      $error("kind: expected %0d, actual %0d", want.kind, got.kind);
      mismatches++;
    end
    if (want.frame_id !== got.frame_id) begin
      $error("frame_id: expected %h, actual %h", want.frame_id, got.frame_id);
      mismatches++;
    end
    if (want.frame_length !== got.frame_length) begin
      $error("frame_length: expected %0d, actual %0d", want.frame_length, got.frame_length);
      mismatches++;
    end
    if (want.frame_flags !== got.frame_flags) begin
      $error("frame_flags: expected %h, actual %h", want.frame_flags, got.frame_flags);
      mismatches++;
    end
    if (want.tag_version !== got.tag_version) begin
      $error("tag_version: expected %h, actual %h", want.tag_version, got.tag_version);
      mismatches++;
    end
    if (want.payload_byte !== got.payload_byte) begin
      $error("payload_byte: expected %h, actual %h", want.payload_byte, got.payload_byte);
      mismatches++;
    end
    if (want.last_of_frame !== got.last_of_frame) begin
      $error("last_of_frame: expected %b, actual %b", want.last_of_frame, got.last_of_frame);
      mismatches++;
    end
    if (want.tag_end !== got.tag_end) begin
      $error("tag_end: expected %b, actual %b", want.tag_end, got.tag_end);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : track_results
    out_beat_t rec;
    bit        produced;
    if (rst) begin
      clear_parser();
    end else begin
      if (in_valid && !in_stall) begin
        produced = parse_file_byte(in_beat.data_byte, in_beat.file_start, rec);
        if (typed_now) pending_records.push_back(typed_record);
        else if (produced) pending_records.push_back(rec);
      end
      if (out_valid && !out_stall) begin
        if (pending_records.size() == 0) begin
          $error("result beat of kind %0d arrived with nothing expected", out_beat.kind);
          mismatches++;
        end else begin
          check_result_beat(pending_records.pop_front(), out_beat);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (idle_mode == 2) out_stall <= $urandom_range(0, 99) < 56;
    else if (idle_mode == 3) out_stall <= $urandom_range(0, 99) < 16;
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_id3v2_frame_stream_parser_core: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic start, input logic typed,
                           input out_beat_t rec);
    int unsigned idle_pct;
    idle_mode = (bytes_sent / PHASE_LEN) % 4;
    idle_pct = (idle_mode == 1) ? 56 : (idle_mode == 3) ? 16 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= '{data_byte: b, file_start: start};
    typed_now <= typed;
    typed_record <= rec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic start);
    send_beat(b, start, 1'b0, NO_RECORD);
  endtask

  task automatic send_random_file();
    int unsigned roll;
    int unsigned tag_size;
    int unsigned used;
    int unsigned room;
    int unsigned id_len;
    int unsigned hdr_len;
    int unsigned frames;
    logic [7:0]  ver;
    logic [31:0] fsize;
    logic [7:0]  hdr [10];
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      for (int i = 0; i < $urandom_range(1, 6); i++) send_byte(8'($urandom), i == 0);
      return;
    end
    roll = $urandom_range(0, 9);
    if (roll < 3) ver = 8'd2;
    else if (roll < 6) ver = 8'd3;
    else if (roll < 8) ver = 8'd4;
    else if (roll == 8) ver = 8'($urandom_range(0, 1));
    else ver = 8'($urandom_range(5, 255));
    roll = $urandom_range(0, 99);
    if (roll < 6) tag_size = 0;
    else if (roll < 10) tag_size = $urandom_range(0, 28'hFFF_FFFF);
    else tag_size = $urandom_range(1, 90);
    hdr[0] = 8'h49;
    hdr[1] = 8'h44;
    hdr[2] = 8'h33;
    hdr[3] = ver;
    hdr[4] = 8'($urandom);
    hdr[5] = 8'($urandom);
    for (int i = 0; i < 4; i++)
      hdr[6 + i] = {1'($urandom), 7'(tag_size >> (7 * (3 - i)))};
    roll = $urandom_range(0, 99);
    if (roll < 5) hdr[$urandom_range(0, 2)] = 8'($urandom);
    for (int i = 0; i < 10; i++) send_byte(hdr[i], i == 0);
    if (roll < 5 || tag_size == 0) return;
    id_len = (ver > 8'd2) ? 4 : 3;
    hdr_len = (ver > 8'd2) ? 10 : 6;
    used = 0;
    frames = 0;
    while (used < tag_size) begin
      if (frames == 8 || $urandom_range(0, 99) < 4) return;
      frames++;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        fsize = 0;
      end else if (roll < 12) begin
        fsize = (id_len == 4) ? $urandom : $urandom_range(1, 24'hFF_FFFF);
      end else if (tag_size - used > hdr_len) begin
        room = tag_size - used - hdr_len;
        fsize = $urandom_range(1, (room < 12) ? room : 12);
      end else begin
        fsize = $urandom_range(1, 3);
      end
      for (int i = 0; i < id_len; i++)
        send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(65, 90)),
                  1'b0);
      for (int i = id_len - 1; i >= 0; i--) send_byte(fsize[8*i +: 8], 1'b0);
      if (id_len == 4) begin
        send_byte(8'($urandom), 1'b0);
        send_byte(8'($urandom), 1'b0);
      end
      used += hdr_len;
      if (fsize == 0 || 64'(used) + 64'(fsize) > 64'(tag_size)) begin
        if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), 1'b0);
        return;
      end
      if (fsize > 64) begin
        for (int i = 0; i < $urandom_range(0, 5); i++) send_byte(8'($urandom), 1'b0);
        return;
      end
      for (int i = 0; i < fsize; i++) send_byte(8'($urandom), 1'b0);
      used += fsize;
    end
    if ($urandom_range(0, 3) == 0) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      send_beat(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].start, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].record);
    while (bytes_sent < BYTE_TARGET) send_random_file();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_id3v2_frame_stream_parser_core: PASS");
    end else begin
      $display("tb_id3v2_frame_stream_parser_core: FAIL");
    end
    $finish;
  end

endmodule
